@@ rtl/chtab_pkg.sv @@
`default_nettype none

package chtab_pkg;

    localparam int TABLE_SLOTS_DEF = 64;
    localparam int TAG_BIT_DEF     = 31;

    localparam int OP_W     = 3;
    localparam int HANDLE_W = 32;
    localparam int TYPE_W   = 8;
    localparam int OBJ_W    = 32;
    localparam int RIGHTS_W = 32;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 2;

    localparam int QDEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_CLOSE     = 3'd1,
        OP_DUPLICATE = 3'd2,
        OP_QUERY     = 3'd3,
        OP_RESOLVE   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_HANDLE = 3'd1,
        ST_TYPE       = 3'd2,
        ST_RIGHTS     = 3'd3,
        ST_FULL       = 3'd4,
        ST_BAD_OBJECT = 3'd5
    } t_status;

    typedef enum logic [ACT_W-1:0] {
        RA_NONE    = 2'd0,
        RA_ADD     = 2'd1,
        RA_RELEASE = 2'd2
    } t_ref_act;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_EXEC = 1'b1
    } t_bstate;

    typedef struct packed {
        t_op                 op;
        t_status             pre;
        logic [TYPE_W-1:0]   req_type;
        logic [OBJ_W-1:0]    object_ref;
        logic [RIGHTS_W-1:0] rights;
    } t_cmd;

    typedef struct packed {
        logic [TYPE_W-1:0]   obj_type;
        logic [RIGHTS_W-1:0] rights;
        logic [OBJ_W-1:0]    obj_ref;
    } t_entry;

    typedef struct packed {
        logic                ok;
        t_status             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [TYPE_W-1:0]   type_out;
        logic [RIGHTS_W-1:0] rights_out;
        logic [OBJ_W-1:0]    object_out;
        t_ref_act            ref_action;
    } t_rsp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

@@ rtl/chtab_req_if.sv @@
`default_nettype none

interface chtab_req_if;
    logic                           valid;
    logic                           ready;
    logic [chtab_pkg::OP_W-1:0]     op;
    logic [chtab_pkg::HANDLE_W-1:0] handle;
    logic [chtab_pkg::TYPE_W-1:0]   req_type;
    logic [chtab_pkg::OBJ_W-1:0]    object_ref;
    logic [chtab_pkg::TYPE_W-1:0]   object_own_type;
    logic [chtab_pkg::RIGHTS_W-1:0] rights;

    modport source (
        output valid, op, handle, req_type, object_ref, object_own_type, rights,
        input  ready
    );
    modport sink (
        input  valid, op, handle, req_type, object_ref, object_own_type, rights,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/chtab_rsp_if.sv @@
`default_nettype none

interface chtab_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           ok;
    logic [chtab_pkg::STATUS_W-1:0] status;
    logic [chtab_pkg::HANDLE_W-1:0] handle_out;
    logic [chtab_pkg::TYPE_W-1:0]   type_out;
    logic [chtab_pkg::RIGHTS_W-1:0] rights_out;
    logic [chtab_pkg::OBJ_W-1:0]    object_out;
    logic [chtab_pkg::ACT_W-1:0]    ref_action;

    modport source (
        output valid, ok, status, handle_out, type_out, rights_out, object_out, ref_action,
        input  ready
    );
    modport sink (
        input  valid, ok, status, handle_out, type_out, rights_out, object_out, ref_action,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/capability_handle_table.sv @@
// capability handle table
// i_req carries one command beat per handshake (op, handle, req_type,
// object_ref, object_own_type, rights); o_rsp returns exactly one result
// beat per command, in order. a beat moves when valid and ready are high.
// the front decodes the op and the handle word and writes a two-entry
// command queue, so i_req.ready only drops while that queue is full.
// the back takes each command through its idle and exec states: idle pops
// the queue, reads the entry memory at the source slot and registers the
// lowest free slot; exec checks the entry and writes the destination slot.
// the back pops a new command only after the last one has moved into the
// output register. an accepted beat passes through the queue, the command
// registers and then the output register, from which its result beat moves.
// the result sits in an output register; while o_rsp.ready is low the
// back holds its command and the front keeps accepting until the queue
// fills. reset is synchronous and clears the valid bits of all slots,
// the queue and the output register's valid bit; entry contents are not cleared.
`default_nettype none

module capability_handle_table #(
    parameter int TABLE_SLOTS = chtab_pkg::TABLE_SLOTS_DEF,
    parameter int TAG_BIT     = chtab_pkg::TAG_BIT_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    chtab_req_if.sink   i_req,
    chtab_rsp_if.source o_rsp
);

    localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DataW = $bits(chtab_pkg::t_cmd) + SlotW;

    logic                     push;
    logic                     pop;
    chtab_pkg::t_cmd          cmd;
    logic [SlotW-1:0]         slot;
    logic [DataW-1:0]         q_data;
    chtab_pkg::t_queue_status q_stat;

    chtab_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .TAG_BIT     (TAG_BIT)
    ) u_front (
        .i_req  (i_req),
        .i_full (q_stat.full),
        .o_push (push),
        .o_cmd  (cmd),
        .o_slot (slot)
    );

    chtab_queue #(
        .DATA_W (DataW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({slot, cmd}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    chtab_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .TAG_BIT     (TAG_BIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_data (q_data),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/chtab_front.sv @@
`default_nettype none

module chtab_front #(
    parameter int TABLE_SLOTS = chtab_pkg::TABLE_SLOTS_DEF,
    parameter int TAG_BIT     = chtab_pkg::TAG_BIT_DEF
) (
    chtab_req_if.sink              i_req,
    input  wire logic              i_full,
    output logic                   o_push,
    output chtab_pkg::t_cmd        o_cmd,
    output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] o_slot
);

    localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [chtab_pkg::HANDLE_W-1:0] TagMask =
        chtab_pkg::HANDLE_W'(1) << TAG_BIT;

    logic [chtab_pkg::HANDLE_W-1:0] hnum;
    logic [chtab_pkg::HANDLE_W-1:0] hnum_m1;
    logic                           handle_ok;

    assign hnum      = i_req.handle & ~TagMask;
    assign hnum_m1   = hnum - chtab_pkg::HANDLE_W'(1);
    assign handle_ok = i_req.handle[TAG_BIT] && (hnum != '0)
                       && (hnum <= chtab_pkg::HANDLE_W'(TABLE_SLOTS));
    assign o_slot    = hnum_m1[SlotW-1:0];

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = chtab_pkg::OP_QUERY;
        o_cmd.pre        = chtab_pkg::ST_OK;
        o_cmd.req_type   = i_req.req_type;
        o_cmd.object_ref = i_req.object_ref;
        o_cmd.rights     = i_req.rights;
        unique case (i_req.op) inside
            chtab_pkg::OP_CREATE: begin
                o_cmd.op = chtab_pkg::OP_CREATE;
                if (i_req.object_ref == '0 || i_req.object_own_type == '0) begin
                    o_cmd.pre = chtab_pkg::ST_BAD_OBJECT;
                end
            end
            chtab_pkg::OP_CLOSE, chtab_pkg::OP_DUPLICATE,
            chtab_pkg::OP_QUERY, chtab_pkg::OP_RESOLVE: begin
                o_cmd.op = chtab_pkg::t_op'(i_req.op);
                if (!handle_ok) begin
                    o_cmd.pre = chtab_pkg::ST_BAD_HANDLE;
                end
            end
            default: begin
                o_cmd.pre = chtab_pkg::ST_BAD_HANDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/chtab_queue.sv @@
`default_nettype none

module chtab_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire logic                  i_pop,
    output logic [DATA_W-1:0]          o_data,
    output chtab_pkg::t_queue_status   o_stat
);

    localparam int PtrW = (chtab_pkg::QDEPTH > 1) ? $clog2(chtab_pkg::QDEPTH) : 1;
    localparam int CntW = $clog2(chtab_pkg::QDEPTH + 1);

    logic [DATA_W-1:0] r_data [chtab_pkg::QDEPTH];
    logic [PtrW-1:0]   r_wptr;
    logic [PtrW-1:0]   r_rptr;
    logic [CntW-1:0]   r_count;

    assign o_data       = r_data[r_rptr];
    assign o_stat.full  = (r_count == CntW'(chtab_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrW'(chtab_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PtrW'(chtab_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chtab_back.sv @@
`default_nettype none

module chtab_back #(
    parameter int TABLE_SLOTS = chtab_pkg::TABLE_SLOTS_DEF,
    parameter int TAG_BIT     = chtab_pkg::TAG_BIT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [$bits(chtab_pkg::t_cmd)
                       + ((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1) - 1:0] i_q_data,
    input  wire chtab_pkg::t_queue_status i_q_stat,
    output logic                      o_pop,
    chtab_rsp_if.source               o_rsp
);

    localparam int SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CmdW  = $bits(chtab_pkg::t_cmd);
    localparam int DataW = CmdW + SlotW;
    localparam logic [chtab_pkg::HANDLE_W-1:0] TagMask =
        chtab_pkg::HANDLE_W'(1) << TAG_BIT;

    chtab_pkg::t_bstate  r_state, n_state;
    chtab_pkg::t_cmd     r_cmd;
    logic [SlotW-1:0]    r_slot;
    chtab_pkg::t_entry   r_rd;
    logic [SlotW-1:0]    r_free;
    logic                r_full;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic                r_out_valid;
    chtab_pkg::t_rsp     r_rsp;
    chtab_pkg::t_entry   r_mem [TABLE_SLOTS];

    chtab_pkg::t_cmd     q_cmd;
    logic [SlotW-1:0]    q_slot;
    logic [SlotW-1:0]    free_slot;
    logic                out_free;
    logic                fire;

    chtab_pkg::t_rsp     n_rsp;
    chtab_pkg::t_status  st;
    chtab_pkg::t_entry   wr_entry;
    logic                wr_en;
    logic                set_valid;
    logic                clr_valid;
    logic                src_valid;
    logic [chtab_pkg::RIGHTS_W-1:0] req;
    logic [chtab_pkg::HANDLE_W-1:0] new_handle;

    assign q_cmd    = chtab_pkg::t_cmd'(i_q_data[CmdW-1:0]);
    assign q_slot   = i_q_data[DataW-1 -: SlotW];
    assign out_free = !r_out_valid || o_rsp.ready;

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SlotW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chtab_pkg::BS_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = chtab_pkg::BS_EXEC;
                end
            end
            chtab_pkg::BS_EXEC: begin
                if (out_free) begin
                    n_state = chtab_pkg::BS_IDLE;
                end
            end
            default: n_state = chtab_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        fire  = 1'b0;
        unique case (r_state)
            chtab_pkg::BS_IDLE: o_pop = !i_q_stat.empty;
            chtab_pkg::BS_EXEC: fire  = out_free;
            default: ;
        endcase
    end

    always_comb begin
        src_valid  = r_valid[r_slot];
        req        = (r_cmd.rights == '0) ? r_rd.rights : r_cmd.rights;
        new_handle = TagMask | (chtab_pkg::HANDLE_W'(r_free) + chtab_pkg::HANDLE_W'(1));
        n_rsp      = '0;
        st         = chtab_pkg::ST_OK;
        wr_en      = 1'b0;
        wr_entry   = r_rd;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        if (r_cmd.pre != chtab_pkg::ST_OK) begin
            st = r_cmd.pre;
        end else begin
            case (r_cmd.op)
                chtab_pkg::OP_CREATE: begin
                    if (r_full) begin
                        st = chtab_pkg::ST_FULL;
                    end else begin
                        wr_en             = 1'b1;
                        set_valid         = 1'b1;
                        wr_entry.obj_type = r_cmd.req_type;
                        wr_entry.rights   = r_cmd.rights;
                        wr_entry.obj_ref  = r_cmd.object_ref;
                        n_rsp.handle_out  = new_handle;
                        n_rsp.object_out  = r_cmd.object_ref;
                        n_rsp.ref_action  = chtab_pkg::RA_ADD;
                    end
                end
                chtab_pkg::OP_CLOSE: begin
                    if (!src_valid) begin
                        st = chtab_pkg::ST_BAD_HANDLE;
                    end else begin
                        clr_valid = 1'b1;
                        if (r_rd.obj_ref != '0) begin
                            n_rsp.object_out = r_rd.obj_ref;
                            n_rsp.ref_action = chtab_pkg::RA_RELEASE;
                        end
                    end
                end
                chtab_pkg::OP_DUPLICATE: begin
                    if (!src_valid) begin
                        st = chtab_pkg::ST_BAD_HANDLE;
                    end else if ((r_rd.rights & req) != req) begin
                        st = chtab_pkg::ST_RIGHTS;
                    end else if (r_full) begin
                        st = chtab_pkg::ST_FULL;
                    end else begin
                        wr_en            = 1'b1;
                        set_valid        = 1'b1;
                        wr_entry.rights  = req;
                        n_rsp.handle_out = new_handle;
                        if (r_rd.obj_ref != '0) begin
                            n_rsp.object_out = r_rd.obj_ref;
                            n_rsp.ref_action = chtab_pkg::RA_ADD;
                        end
                    end
                end
                chtab_pkg::OP_QUERY: begin
                    if (!src_valid) begin
                        st = chtab_pkg::ST_BAD_HANDLE;
                    end else begin
                        n_rsp.type_out   = r_rd.obj_type;
                        n_rsp.rights_out = r_rd.rights;
                    end
                end
                chtab_pkg::OP_RESOLVE: begin
                    if (!src_valid) begin
                        st = chtab_pkg::ST_BAD_HANDLE;
                    end else if (r_cmd.req_type != '0 && r_rd.obj_type != r_cmd.req_type) begin
                        st = chtab_pkg::ST_TYPE;
                    end else if ((r_rd.rights & r_cmd.rights) != r_cmd.rights) begin
                        st = chtab_pkg::ST_RIGHTS;
                    end else begin
                        n_rsp.object_out = r_rd.obj_ref;
                    end
                end
                default: st = chtab_pkg::ST_BAD_HANDLE;
            endcase
        end
        n_rsp.ok     = (st == chtab_pkg::ST_OK);
        n_rsp.status = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chtab_pkg::BS_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire && set_valid) begin
                r_valid[r_free] <= 1'b1;
            end
            if (fire && clr_valid) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= q_cmd;
            r_slot <= q_slot;
            r_free <= free_slot;
            r_full <= &r_valid;
            r_rd   <= r_mem[q_slot];
        end
        if (fire && wr_en) begin
            r_mem[r_free] <= wr_entry;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_rsp.ok;
    assign o_rsp.status     = r_rsp.status;
    assign o_rsp.handle_out = r_rsp.handle_out;
    assign o_rsp.type_out   = r_rsp.type_out;
    assign o_rsp.rights_out = r_rsp.rights_out;
    assign o_rsp.object_out = r_rsp.object_out;
    assign o_rsp.ref_action = r_rsp.ref_action;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_stat.empty)
        else $error("pop from empty queue");

    a_pop_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == chtab_pkg::BS_EXEC))
        else $error("popped beat not executed next");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == chtab_pkg::BS_EXEC && r_full) |-> (&r_valid))
        else $error("full flag disagrees with valid bits");

    a_create_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_rsp.ok && r_cmd.op == chtab_pkg::OP_CREATE) |=> r_valid[$past(r_free)])
        else $error("created slot not marked valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !fire)
        else $error("waiting result overwritten");

endmodule

`default_nettype wire
